// ===== sv/srr_pkg.sv =====
// Shared types and constants for the selective-repeat reorder receiver.
package srr_pkg;

  localparam int unsigned SEQ_W   = 8;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned HDL_W   = 16;
  localparam int unsigned ENTRY_W = HDL_W + LEN_W;

  localparam logic [3:0] ST_IN_ORDER   = 4'd0;
  localparam logic [3:0] ST_PARKED     = 4'd1;
  localparam logic [3:0] ST_DUPLICATE  = 4'd2;
  localparam logic [3:0] ST_OUTSIDE    = 4'd3;
  localparam logic [3:0] ST_QUEUE_FULL = 4'd4;
  localparam logic [3:0] ST_OVERSIZE   = 4'd5;
  localparam logic [3:0] ST_POPPED     = 4'd6;
  localparam logic [3:0] ST_POP_EMPTY  = 4'd7;
  localparam logic [3:0] ST_WIN_FULL   = 4'd8;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Pre-classified command handed from the front to the back.
  typedef struct packed {
    logic              kind;
    logic              oversize;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic [TS_W-1:0]   ts;
    logic [HDL_W-1:0]  handle;
  } srr_cmd_t;

endpackage

// ===== sv/srr_if.sv =====
// Handshake channel interfaces for input and result transactions.
interface srr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  seq_number;
  logic [9:0]  payload_length;
  logic [31:0] sender_timestamp;
  logic [15:0] packet_handle;

  modport source (output valid, kind, seq_number, payload_length, sender_timestamp,
                  packet_handle, input ready);
  modport sink   (input valid, kind, seq_number, payload_length, sender_timestamp,
                  packet_handle, output ready);
endinterface

interface srr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        ack_valid;
  logic [7:0]  ack_seq_number;
  logic [5:0]  ack_window;
  logic [31:0] ack_timestamp;
  logic [5:0]  released_count;
  logic [15:0] out_handle;
  logic [9:0]  out_length;
  logic        out_eof;

  modport source (output valid, status, ack_valid, ack_seq_number, ack_window,
                  ack_timestamp, released_count, out_handle, out_length, out_eof,
                  input ready);
  modport sink   (input valid, status, ack_valid, ack_seq_number, ack_window,
                  ack_timestamp, released_count, out_handle, out_length, out_eof,
                  output ready);
endinterface

// ===== sv/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/srr_front.sv =====
// Front end: accepts transactions, reduces sequence, flags oversize, 2-entry queue.
module srr_front
  import srr_pkg::*;
#(
  parameter int unsigned SEQ_SPACE = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  srr_in_if.sink         in_ch,
  input  logic           cfg_we,
  input  logic [9:0]     cfg_wdata,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output srr_cmd_t       cmd
);
  logic [9:0]       max_payload_r;
  srr_cmd_t         fifo_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;
  logic [SEQ_W-1:0] seq_mod [256];
  logic             push, pop;
  srr_cmd_t         new_cmd;

  // sequence modulo table, constant
  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign seq_mod[i] = SEQ_W'(i % SEQ_SPACE);
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = fifo_r[rptr_r];

  always_comb begin
    new_cmd.kind     = in_ch.kind;
    new_cmd.oversize = (in_ch.payload_length > max_payload_r);
    new_cmd.seq      = seq_mod[in_ch.seq_number];
    new_cmd.len      = in_ch.payload_length;
    new_cmd.ts       = in_ch.sender_timestamp;
    new_cmd.handle   = in_ch.packet_handle;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= new_cmd;
    end
    if (!rst_n) begin
      max_payload_r <= 10'd512;
      wptr_r        <= 1'b0;
      rptr_r        <= 1'b0;
      cnt_r         <= 2'd0;
    end else begin
      if (cfg_we) begin
        max_payload_r <= cfg_wdata;
      end
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== sv/srr_back.sv =====
// Back end: window and write-out queue state, drain sequencer, result register.
module srr_back
  import srr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 32,
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned SEQ_SPACE    = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  srr_cmd_t  cmd,
  srr_out_if.source out_ch
);
  localparam int unsigned WAW = $clog2(WINDOW_DEPTH);
  localparam int unsigned WCW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam logic [WCW-1:0]   WDEPTH  = WCW'(WINDOW_DEPTH);
  localparam logic [QAW-1:0]   QLAST   = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QAW:0]     QDEPTH  = (QAW+1)'(QUEUE_DEPTH);
  localparam logic [WAW:0]     WDEPTHA = (WAW+1)'(WINDOW_DEPTH);
  localparam logic [SEQ_W-1:0] SLAST   = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [9:0]       SSPACE  = 10'(SEQ_SPACE);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLASS = 6'b000010,
    S_POPW  = 6'b000100,
    S_DRD   = 6'b001000,
    S_DWR   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  srr_cmd_t              cur_r, cur_nxt;
  logic [SEQ_W-1:0]      exp_r, exp_nxt;
  logic [WAW-1:0]        base_r, base_nxt;
  logic [WINDOW_DEPTH-1:0] occ_r, occ_nxt;
  logic [WCW-1:0]        wcnt_r, wcnt_nxt;
  logic [QAW-1:0]        qhead_r, qhead_nxt;
  logic [QAW-1:0]        qcnt_r, qcnt_nxt;
  logic [TS_W-1:0]       ts_r, ts_nxt;
  logic [3:0]            stat_r, stat_nxt;
  logic                  ack_r, ack_nxt;
  logic [WCW-1:0]        rel_r, rel_nxt;
  logic [ENTRY_W-1:0]    pop_r, pop_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic [3:0]            res_status_r, res_status_nxt;
  logic                  res_ack_r, res_ack_nxt;
  logic [SEQ_W-1:0]      res_seq_r, res_seq_nxt;
  logic [5:0]            res_win_r, res_win_nxt;
  logic [TS_W-1:0]       res_ts_r, res_ts_nxt;
  logic [5:0]            res_rel_r, res_rel_nxt;
  logic [ENTRY_W-1:0]    res_pop_r, res_pop_nxt;

  logic                  wr_we, q_we;
  logic [WAW-1:0]        wr_waddr, wr_raddr;
  logic [QAW-1:0]        q_waddr;
  logic [ENTRY_W-1:0]    q_wdata, wr_rdata, q_rdata;
  logic [SEQ_W-1:0]      exp_inc;
  logic [QAW-1:0]        qtail;
  logic [QAW:0]          qsum;
  logic [9:0]            seq_off, dtmp;
  logic [WAW:0]          ssum;
  logic [WAW-1:0]        slot, base_inc;
  logic                  q_room;

  srr_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW_DEPTH)) u_win_ram (
    .clk(clk), .we(wr_we), .waddr(wr_waddr), .wdata({cur_r.handle, cur_r.len}),
    .raddr(wr_raddr), .rdata(wr_rdata)
  );

  srr_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(qhead_r), .rdata(q_rdata)
  );

  always_comb begin
    exp_inc  = (exp_r == SLAST) ? '0 : exp_r + SEQ_W'(1);
    base_inc = (base_r == WAW'(WINDOW_DEPTH - 1)) ? '0 : base_r + WAW'(1);
    qsum     = {1'b0, qhead_r} + {1'b0, qcnt_r};
    qtail    = (qsum >= QDEPTH) ? QAW'(qsum - QDEPTH) : qsum[QAW-1:0];
    q_room   = (qcnt_r < QLAST);
    dtmp     = {2'b00, cur_r.seq} - {2'b00, exp_r} - 10'd1;
    seq_off  = dtmp[9] ? dtmp + SSPACE : dtmp;
    ssum     = {1'b0, base_r} + {1'b0, seq_off[WAW-1:0]};
    slot     = (ssum >= WDEPTHA) ? WAW'(ssum - WDEPTHA) : ssum[WAW-1:0];
  end

  assign cmd_ready = (state_r == S_IDLE) && !res_valid_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    exp_nxt   = exp_r;
    base_nxt  = base_r;
    occ_nxt   = occ_r;
    wcnt_nxt  = wcnt_r;
    qhead_nxt = qhead_r;
    qcnt_nxt  = qcnt_r;
    ts_nxt    = ts_r;
    stat_nxt  = stat_r;
    ack_nxt   = ack_r;
    rel_nxt   = rel_r;
    pop_nxt   = pop_r;
    res_valid_nxt  = res_valid_r && !out_ch.ready;
    res_status_nxt = res_status_r;
    res_ack_nxt    = res_ack_r;
    res_seq_nxt    = res_seq_r;
    res_win_nxt    = res_win_r;
    res_ts_nxt     = res_ts_r;
    res_rel_nxt    = res_rel_r;
    res_pop_nxt    = res_pop_r;
    wr_we    = 1'b0;
    wr_waddr = slot;
    wr_raddr = base_r;
    q_we     = 1'b0;
    q_waddr  = qtail;
    q_wdata  = {cur_r.handle, cur_r.len};

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          cur_nxt   = cmd;
          ack_nxt   = 1'b0;
          rel_nxt   = '0;
          pop_nxt   = '0;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        state_nxt = S_FIN;
        if (cur_r.kind == KIND_POP) begin
          if (qcnt_r != '0) begin
            state_nxt = S_POPW;   // head entry read in flight
          end else begin
            stat_nxt = ST_POP_EMPTY;
          end
        end else if (cur_r.oversize) begin
          stat_nxt = ST_OVERSIZE;
        end else begin
          ts_nxt = cur_r.ts;
          if (cur_r.seq == exp_r) begin
            ack_nxt = 1'b1;
            if (q_room) begin
              q_we      = 1'b1;
              qcnt_nxt  = qcnt_r + QAW'(1);
              exp_nxt   = exp_inc;
              stat_nxt  = ST_IN_ORDER;
              state_nxt = S_DRD;
            end else begin
              stat_nxt = ST_QUEUE_FULL;
            end
          end else if (wcnt_r >= WDEPTH) begin
            stat_nxt = ST_WIN_FULL;
          end else begin
            ack_nxt = 1'b1;
            if (seq_off >= 10'(WINDOW_DEPTH)) begin
              stat_nxt = ST_OUTSIDE;
            end else if (occ_r[slot]) begin
              stat_nxt = ST_DUPLICATE;
            end else begin
              wr_we         = 1'b1;
              occ_nxt[slot] = 1'b1;
              wcnt_nxt      = wcnt_r + WCW'(1);
              stat_nxt      = ST_PARKED;
            end
          end
        end
      end
      S_POPW: begin
        pop_nxt   = q_rdata;
        qhead_nxt = (qhead_r == QLAST) ? '0 : qhead_r + QAW'(1);
        qcnt_nxt  = qcnt_r - QAW'(1);
        stat_nxt  = ST_POPPED;
        state_nxt = S_FIN;
      end
      S_DRD: begin
        // base points at the slot of the expected number
        if (occ_r[base_r] && q_room) begin
          state_nxt = S_DWR;
        end else begin
          if (occ_r[base_r]) begin
            occ_nxt[base_r] = 1'b0;   // blocked by full queue: discard
            wcnt_nxt        = wcnt_r - WCW'(1);
          end
          base_nxt  = base_inc;
          state_nxt = S_FIN;
        end
      end
      S_DWR: begin
        q_we            = 1'b1;
        q_wdata         = wr_rdata;
        qcnt_nxt        = qcnt_r + QAW'(1);
        occ_nxt[base_r] = 1'b0;
        wcnt_nxt        = wcnt_r - WCW'(1);
        base_nxt        = base_inc;
        exp_nxt         = exp_inc;
        rel_nxt         = rel_r + WCW'(1);
        state_nxt       = S_DRD;
      end
      S_FIN: begin
        res_valid_nxt  = 1'b1;
        res_status_nxt = stat_r;
        res_ack_nxt    = ack_r;
        res_seq_nxt    = ack_r ? exp_r : '0;
        res_win_nxt    = ack_r ? 6'(WDEPTH - wcnt_r) : '0;
        res_ts_nxt     = ack_r ? ts_r : '0;
        res_rel_nxt    = 6'(rel_r);
        res_pop_nxt    = pop_r;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    stat_r       <= stat_nxt;
    ack_r        <= ack_nxt;
    rel_r        <= rel_nxt;
    pop_r        <= pop_nxt;
    res_status_r <= res_status_nxt;
    res_ack_r    <= res_ack_nxt;
    res_seq_r    <= res_seq_nxt;
    res_win_r    <= res_win_nxt;
    res_ts_r     <= res_ts_nxt;
    res_rel_r    <= res_rel_nxt;
    res_pop_r    <= res_pop_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= '0;
      base_r      <= '0;
      occ_r       <= '0;
      wcnt_r      <= '0;
      qhead_r     <= '0;
      qcnt_r      <= '0;
      ts_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      base_r      <= base_nxt;
      occ_r       <= occ_nxt;
      wcnt_r      <= wcnt_nxt;
      qhead_r     <= qhead_nxt;
      qcnt_r      <= qcnt_nxt;
      ts_r        <= ts_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign out_ch.valid          = res_valid_r;
  assign out_ch.status         = res_status_r;
  assign out_ch.ack_valid      = res_ack_r;
  assign out_ch.ack_seq_number = res_seq_r;
  assign out_ch.ack_window     = res_win_r;
  assign out_ch.ack_timestamp  = res_ts_r;
  assign out_ch.released_count = res_rel_r;
  assign out_ch.out_handle     = res_pop_r[ENTRY_W-1:LEN_W];
  assign out_ch.out_length     = res_pop_r[LEN_W-1:0];
  assign out_ch.out_eof        = (res_status_r == ST_POPPED) && (res_pop_r[LEN_W-1:0] == '0);
endmodule

// ===== sv/selective_repeat_reorder_receiver_unit.sv =====
// Top level of the selective-repeat reorder receiver.
//
// Receive side of a selective-repeat window. Each input transaction is a data packet
// descriptor or a pop request; each produces exactly one result transaction. A front
// stage registers the transaction in a two-entry queue, reducing the sequence number
// and checking the length against max_payload; a back sequencer owns the reorder
// window and the write-out queue (both in RAM) and holds the result in an output
// register. A pop on an empty queue, refused and parked packets pass the classify and
// finish states; a pop that returns a packet adds a state for the queue RAM read; an
// in-order packet adds a window read state, and a write and a read state per parked
// packet it releases, set by the one-read window RAM feeding the queue RAM. The next
// transaction starts only after the result register has been accepted.
// cfg_we/cfg_wdata write max_payload (reset 512); write it only while idle.
module selective_repeat_reorder_receiver_unit
  import srr_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 32,
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned SEQ_SPACE    = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  srr_in_if.sink     in_ch,
  srr_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);
  logic     cmd_valid;
  logic     cmd_ready;
  srr_cmd_t cmd;

  // accept and pre-classify
  srr_front #(.SEQ_SPACE(SEQ_SPACE)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  // window, queue, release sequencing, result register
  srr_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH), .QUEUE_DEPTH(QUEUE_DEPTH), .SEQ_SPACE(SEQ_SPACE)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_ch(out_ch)
  );
endmodule

// ===== tb/sv/tb_selective_repeat_reorder_receiver_unit.sv =====
// Testbench for the selective-repeat reorder receiver: self-checking, random and directed traffic.
module tb_selective_repeat_reorder_receiver_unit;
  import srr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_SLOTS   = 32;
  localparam int WQ_DEPTH    = 64;
  localparam int SEQ_MOD     = 256;
  localparam int SETTLE_CYC  = 100;   // settle time: covers a release of the whole window, plus margin
  localparam int HOLD_CYC    = 300;   // long receiver back-pressure stretch
  localparam int STALL_LIMIT = 3000;  // cycles with no transaction before giving up
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic              kind;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic [TS_W-1:0]   ts;
    logic [HDL_W-1:0]  handle;
  } pkt_t;

  typedef struct packed {
    logic [3:0]        status;
    logic              ack;
    logic [7:0]        ack_seq;
    logic [5:0]        ack_win;
    logic [31:0]       ack_ts;
    logic [5:0]        released;
    logic [15:0]       handle;
    logic [9:0]        length;
    logic              eof;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [9:0] cfg_wdata;

  srr_in_if  in_ch();
  srr_out_if out_ch();

  selective_repeat_reorder_receiver_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the receiver state, advanced once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [9:0]         max_len;
  int                 next_seq;
  int                 win_base;
  bit                 win_busy [WIN_SLOTS];
  logic [ENTRY_W-1:0] win_mem  [WIN_SLOTS];
  int                 win_fill;
  logic [ENTRY_W-1:0] wq_mem   [WQ_DEPTH];
  int                 wq_head;
  int                 wq_fill;
  logic [31:0]        echo_ts;

  pkt_t     pend[$];      // transactions waiting to be offered
  verdict_t ack_q[$];     // expected results, oldest first
  int       mismatches = 0;
  bit       gaps_on = 1'b1;
  bit       hold_req = 1'b0;
  int       gen_seq;      // generator's idea of the next in-order number

  function automatic void wq_push(input logic [ENTRY_W-1:0] e);
    wq_mem[(wq_head + wq_fill) % WQ_DEPTH] = e;
    wq_fill++;
  endfunction

  function automatic verdict_t receive_packet(input pkt_t p);
    verdict_t r;
    logic [ENTRY_W-1:0] e;
    int d;
    int slot;
    r = '0;
    if (p.kind == KIND_POP) begin
      if (wq_fill > 0) begin
        e        = wq_mem[wq_head];
        r.handle = e[ENTRY_W-1:LEN_W];
        r.length = e[LEN_W-1:0];
        r.eof    = (e[LEN_W-1:0] == '0);
        wq_head  = (wq_head + 1) % WQ_DEPTH;
        wq_fill--;
        r.status = ST_POPPED;
      end else begin
        r.status = ST_POP_EMPTY;
      end
    end else if (p.len > max_len) begin
      r.status = ST_OVERSIZE;
    end else begin
      echo_ts = p.ts;
      e = {p.handle, p.len};
      if (int'(p.seq) == next_seq) begin
        if (wq_fill + 1 < WQ_DEPTH) begin
          next_seq = (next_seq + 1) % SEQ_MOD;
          wq_push(e);
          // hand over parked successors until a gap or the queue limit
          while (win_busy[win_base] && wq_fill + 1 < WQ_DEPTH) begin
            wq_push(win_mem[win_base]);
            win_busy[win_base] = 1'b0;
            win_fill--;
            win_base = (win_base + 1) % WIN_SLOTS;
            next_seq = (next_seq + 1) % SEQ_MOD;
            r.released++;
          end
          // blocked release: the packet now due is dropped, sender resends it
          if (win_busy[win_base]) begin
            win_busy[win_base] = 1'b0;
            win_fill--;
          end
          win_base = (win_base + 1) % WIN_SLOTS;
          r.status = ST_IN_ORDER;
        end else begin
          r.status = ST_QUEUE_FULL;
        end
        r.ack = 1'b1;
      end else if (win_fill >= WIN_SLOTS) begin
        r.status = ST_WIN_FULL;
      end else begin
        d = (int'(p.seq) + 2 * SEQ_MOD - next_seq - 1) % SEQ_MOD;
        if (d >= WIN_SLOTS) begin
          r.status = ST_OUTSIDE;
        end else begin
          slot = (win_base + d) % WIN_SLOTS;
          if (win_busy[slot]) begin
            r.status = ST_DUPLICATE;
          end else begin
            win_busy[slot] = 1'b1;
            win_mem[slot]  = e;
            win_fill++;
            r.status = ST_PARKED;
          end
        end
        r.ack = 1'b1;
      end
    end
    if (r.ack) begin
      r.ack_seq = next_seq[7:0];
      r.ack_win = 6'(WIN_SLOTS - win_fill);
      r.ack_ts  = echo_ts;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers pending transactions, with a random gap after each one while gaps_on is set.
  // ---------------------------------------------------------------------------
  int send_gap;

  always @(posedge clk) begin
    pkt_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pend.size() != 0) begin
        p = pend.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.kind             <= p.kind;
        in_ch.seq_number       <= p.seq;
        in_ch.payload_length   <= p.len;
        in_ch.sender_timestamp <= p.ts;
        in_ch.packet_handle    <= p.handle;
        send_gap <= gaps_on ? int'($urandom_range(0, 13)) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Accepted input transaction: run the shadow model, queue the expectation.
  always @(posedge clk) begin
    pkt_t p;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.kind   = in_ch.kind;
      p.seq    = in_ch.seq_number;
      p.len    = in_ch.payload_length;
      p.ts     = in_ch.sender_timestamp;
      p.handle = in_ch.packet_handle;
      ack_q.push_back(receive_packet(p));
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each result while gaps_on is set, plus an optional long hold.
  // ---------------------------------------------------------------------------
  int rx_stall;
  int hold_left;

  always @(posedge clk) begin
    int s;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall     <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      hold_left    <= HOLD_CYC;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      s = gaps_on ? int'($urandom_range(0, 13)) : 0;
      rx_stall     <= s;
      out_ch.ready <= (s == 0);
    end else if (!out_ch.ready) begin
      if (rx_stall > 1) begin
        rx_stall <= rx_stall - 1;
      end else begin
        rx_stall     <= 0;
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker: every result against the oldest expectation.
  always @(posedge clk) begin
    verdict_t w;
    verdict_t g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g.status   = out_ch.status;
      g.ack      = out_ch.ack_valid;
      g.ack_seq  = out_ch.ack_seq_number;
      g.ack_win  = out_ch.ack_window;
      g.ack_ts   = out_ch.ack_timestamp;
      g.released = out_ch.released_count;
      g.handle   = out_ch.out_handle;
      g.length   = out_ch.out_length;
      g.eof      = out_ch.out_eof;
      if (ack_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transaction: status %0d", g.status);
      end else begin
        w = ack_q.pop_front();
        if (g !== w) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch exp: st %0d ack %0b seq %0d win %0d ts %h rel %0d h %h len %0d eof %0b",
                     w.status, w.ack, w.ack_seq, w.ack_win, w.ack_ts, w.released,
                     w.handle, w.length, w.eof);
            $display("         got: st %0d ack %0b seq %0d win %0d ts %h rel %0d h %h len %0d eof %0b",
                     g.status, g.ack, g.ack_seq, g.ack_win, g.ack_ts, g.released,
                     g.handle, g.length, g.eof);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side.
  int quiet_cyc = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= STALL_LIMIT) begin
      $display("tb_selective_repeat_reorder_receiver_unit: errors");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [9:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 10'd0;                       // end of file marker
    if (r < 14) return 10'($urandom_range(0, 1023)); // may be oversize
    return 10'($urandom_range(0, max_len));
  endfunction

  task automatic add_data(input int seq, input logic [9:0] len);
    pkt_t p;
    p.kind   = KIND_DATA;
    p.seq    = 8'(seq);
    p.len    = len;
    p.ts     = $urandom();
    p.handle = 16'($urandom());
    pend.push_back(p);
  endtask

  task automatic add_pop();
    pkt_t p;
    p = '{kind: KIND_POP, seq: 8'($urandom()), len: 10'($urandom()),
          ts: $urandom(), handle: 16'($urandom())};
    pend.push_back(p);
  endtask

  // Wait until every offered transaction has its result, then let the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pend.size() != 0 || ack_q.size() != 0 || in_ch.valid);
    repeat (SETTLE_CYC) @(negedge clk);
    gen_seq = next_seq;
  endtask

  task automatic write_max_len(input logic [9:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    max_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Only meaningful once drained: pops as many entries as the shadow queue holds.
  task automatic empty_queue();
    repeat (wq_fill) add_pop();
  endtask

  // Bursts of consecutive numbers in shuffled order, mixed with pops,
  // resends and noise. pop_pct sets how fast the write-out queue drains.
  task automatic reorder_traffic(input int count, input int pop_pct);
    int seqs[8];
    int k, j, t, n;
    n = 0;
    while (n < count) begin
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) seqs[i] = (gen_seq + i) % SEQ_MOD;
      for (int i = k - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = seqs[i]; seqs[i] = seqs[j]; seqs[j] = t;
      end
      for (int i = 0; i < k; i++) begin
        add_data(seqs[i], pick_len());
        n++;
        if ($urandom_range(0, 99) < 10) begin
          add_data(seqs[$urandom_range(0, i)], pick_len());   // resend
          n++;
        end
        if ($urandom_range(0, 99) < 8) begin
          add_data($urandom_range(0, 255), pick_len());       // noise
          n++;
        end
        if ($urandom_range(0, 99) < pop_pct) begin
          add_pop();
          n++;
        end
      end
      gen_seq = (gen_seq + k) % SEQ_MOD;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [9:0] cfg_vals[4];
    pkt_t p;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_DATA;
    in_ch.seq_number       = '0;
    in_ch.payload_length   = '0;
    in_ch.sender_timestamp = '0;
    in_ch.packet_handle    = '0;
    out_ch.ready = 1'b0;

    max_len  = 10'd512;
    next_seq = 0;
    win_base = 0;
    win_fill = 0;
    wq_head  = 0;
    wq_fill  = 0;
    echo_ts  = '0;
    foreach (win_busy[i]) win_busy[i] = 1'b0;
    gen_seq  = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pop, field limits, and every status but window full and queue full.
    add_pop();
    add_data(0, 10'd0);                               // in order, EOF marker
    p = '{kind: KIND_DATA, seq: 8'd1, len: 10'd512, ts: 32'hFFFF_FFFF, handle: 16'hFFFF};
    pend.push_back(p);                                // length exactly at limit
    add_data(2, 10'd513);                             // oversize
    add_data(2, 10'd1023);                            // oversize, all length bits
    add_data(4, 10'd7);                               // parked
    add_data(4, 10'd8);                               // duplicate
    add_data(3 + WIN_SLOTS, 10'd3);                   // first number past the window
    add_data(2 + WIN_SLOTS, 10'd3);                   // last slot of the window
    add_data(255, 10'd3);                             // behind expected: outside
    add_data(2, 10'd5);                               // in order, releases none
    add_data(3, 10'd6);                               // in order, releases the parked one
    repeat (5) add_pop();                             // EOF pop, full-field pop, three more
    wait_drained();

    // Fill the window completely, trip window-full, then release all 32.
    write_max_len(10'd1023);
    begin
      int perm[WIN_SLOTS];
      int j, t;
      for (int i = 0; i < WIN_SLOTS; i++) perm[i] = i + 1;
      for (int i = WIN_SLOTS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = perm[i]; perm[i] = perm[j]; perm[j] = t;
      end
      foreach (perm[i]) add_data((gen_seq + perm[i]) % SEQ_MOD, pick_len());
      add_data((gen_seq + 40) % SEQ_MOD, 10'd9);      // window full
      add_data((gen_seq + 5) % SEQ_MOD, 10'd9);       // window full beats duplicate
      add_data(gen_seq, 10'd1);                       // releases the whole window
    end
    wait_drained();
    empty_queue();
    wait_drained();

    // Fill the write-out queue: blocked release, then queue-full drops.
    // The receiver also holds off for a long stretch so the input stalls.
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < WQ_DEPTH - 2; i++) add_data((gen_seq + i) % SEQ_MOD, 10'd4);
    gen_seq = (gen_seq + WQ_DEPTH - 2) % SEQ_MOD;
    add_data((gen_seq + 1) % SEQ_MOD, 10'd4);         // parked
    add_data((gen_seq + 2) % SEQ_MOD, 10'd4);         // parked
    add_data(gen_seq, 10'd4);                         // fills queue, release blocked
    add_data((gen_seq + 1) % SEQ_MOD, 10'd4);         // queue full
    add_data((gen_seq + 1) % SEQ_MOD, 10'd4);
    repeat (3) add_pop();
    add_data((gen_seq + 1) % SEQ_MOD, 10'd4);         // resent, now accepted
    wait_drained();
    gaps_on = 1'b1;
    empty_queue();
    wait_drained();

    // Random phases across several limits; max_len 0 lets only EOF packets in.
    cfg_vals = '{10'd0, 10'd1023, 10'd512, 10'd100};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) write_max_len(cfg_vals[(ph / 3) % 4]);
      else if (ph == 7) write_max_len(10'($urandom_range(1, 1022)));
      gaps_on = (ph % 4 != 2);
      if (ph == 5) hold_req = 1'b1;
      reorder_traffic(100, (ph % 5 == 4) ? 20 : 45);
      wait_drained();
      if (ph % 3 == 2) begin
        empty_queue();
        wait_drained();
      end
    end

    if (mismatches == 0) begin
      $display("tb_selective_repeat_reorder_receiver_unit: clean");
    end else begin
      $display("tb_selective_repeat_reorder_receiver_unit: errors");
    end
    $finish;
  end

endmodule
